// File: design/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/b32dns_pkg.sv
`timescale 1ns / 1ps

package b32dns_pkg;

  // Result slots per accepted word: dot, data pairs then the five suffix characters.
  localparam int NumSlots  = 11;
  localparam int NumData   = 3;
  localparam int SlotSuf0  = 2 * NumData;
  localparam int SlotLast  = NumSlots - 1;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 9;

  localparam logic [7:0] CharDot  = 8'h2E;
  localparam logic [7:0] CharG    = 8'h47;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharA    = 8'h41;
  localparam logic [7:0] CharTwo  = 8'h32;

  localparam logic [6:0] TagReset     = 7'd0;
  localparam logic [7:0] MaxInReset   = 8'd153;
  localparam logic [8:0] MaxNameReset = 9'd253;
  localparam logic [7:0] LabelReset   = 8'd63;
  localparam logic [7:0] LabelMin     = 8'd3;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTag     = 2'd0,
    CfgMaxIn   = 2'd1,
    CfgMaxName = 2'd2,
    CfgLabel   = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StInLong   = 2'd1,
    StNameLong = 2'd2
  } status_e;

  typedef struct packed {
    logic [6:0] tag;
    logic [7:0] max_in;
    logic [8:0] max_name;
    logic [7:0] label_len;
  } cfg_t;

  typedef struct packed {
    logic [3:0] bit_buf;
    logic [2:0] bit_cnt;
    logic [7:0] label_pos;
    logic [8:0] name_len;
    logic [7:0] byte_cnt;
  } enc_state_t;

  typedef struct packed {
    logic [NumSlots-1:0][7:0] chars;
    logic [NumSlots-1:0]      mask;
    logic                     last;
    status_e                  status;
  } slots_t;

  function automatic logic [7:0] b32_char(logic [4:0] idx);
    logic [7:0] ch;
    if (idx < 5'd26) begin
      ch = CharA + 8'(idx);
    end else begin
      ch = CharTwo + 8'(idx - 5'd26);
    end
    return ch;
  endfunction

  // tag / 10 by reciprocal: exact over the whole 7-bit range.
  function automatic logic [3:0] tag_tens(logic [6:0] tag);
    logic [14:0] prod;
    prod = 15'(tag) * 15'd205;
    return prod[14:11];
  endfunction

  function automatic logic [3:0] tag_ones(logic [6:0] tag);
    logic [6:0] t10;
    t10 = 7'(tag_tens(tag)) * 7'd10;
    return 4'(tag - t10);
  endfunction

endpackage

// File: design/b32dns_expand.sv
`timescale 1ns / 1ps

module b32dns_expand import b32dns_pkg::*; (
  input  cfg_t       cfg_i,
  input  enc_state_t st_i,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  output slots_t     slots_o,
  output enc_state_t st_o
);

  logic [11:0]        acc;
  logic [2:0]         cnt_clamp;
  logic [3:0]         bits;
  logic               two;
  logic [11:0]        acc_sh0;
  logic [11:0]        acc_sh1;
  logic [11:0]        acc_tail;
  logic [3:0]         rem_w;
  logic [2:0]         rem;
  logic [7:0]         limit;
  logic [NumData-1:0][4:0] idx;
  logic [NumData-1:0] dvalid;
  logic [NumData-1:0] dot;
  logic [7:0]         pos;
  logic [3:0]         cnt;
  logic [9:0]         nl_sum;
  logic [8:0]         nl_new;
  logic [3:0]         keep_mask;

  assign acc       = {st_i.bit_buf, data_byte_i};
  assign cnt_clamp = (st_i.bit_cnt > 3'd4) ? 3'd4 : st_i.bit_cnt;
  assign bits      = 4'(cnt_clamp) + 4'd8;
  assign two       = (bits >= 4'd10);
  assign acc_sh0   = acc >> (bits - 4'd5);
  assign acc_sh1   = acc >> (bits - 4'd10);
  assign rem_w     = two ? (bits - 4'd10) : (bits - 4'd5);
  assign rem       = rem_w[2:0];
  assign acc_tail  = acc << (3'd5 - rem);
  assign limit     = (cfg_i.label_len < LabelMin) ? LabelMin : cfg_i.label_len;
  assign keep_mask = 4'((5'd1 << rem) - 5'd1);

  assign idx[0]    = acc_sh0[4:0];
  assign idx[1]    = acc_sh1[4:0];
  assign idx[2]    = acc_tail[4:0];
  assign dvalid[0] = 1'b1;
  assign dvalid[1] = two;
  assign dvalid[2] = last_byte_i && (rem != 3'd0);

  // Walk the data characters in order, breaking the label where it is full.
  always_comb begin
    pos = st_i.label_pos;
    cnt = last_byte_i ? 4'd5 : 4'd0;
    for (int k = 0; k < NumData; k++) begin
      dot[k] = dvalid[k] && (pos >= limit);
      if (dvalid[k]) begin
        pos = dot[k] ? 8'd1 : pos + 8'd1;
      end
      cnt = cnt + 4'(dot[k]) + 4'(dvalid[k]);
    end
  end

  assign nl_sum = 10'(st_i.name_len) + 10'(cnt);
  assign nl_new = nl_sum[9] ? 9'h1FF : nl_sum[8:0];

  always_comb begin
    for (int k = 0; k < NumData; k++) begin
      slots_o.chars[2*k]     = CharDot;
      slots_o.mask[2*k]      = dot[k];
      slots_o.chars[2*k + 1] = b32_char(idx[k]);
      slots_o.mask[2*k + 1]  = dvalid[k];
    end
    slots_o.chars[SlotSuf0]     = CharDot;
    slots_o.chars[SlotSuf0 + 1] = CharG;
    slots_o.chars[SlotSuf0 + 2] = CharZero + 8'(tag_tens(cfg_i.tag));
    slots_o.chars[SlotSuf0 + 3] = CharZero + 8'(tag_ones(cfg_i.tag));
    slots_o.chars[SlotSuf0 + 4] = CharDot;
    for (int k = SlotSuf0; k < NumSlots; k++) begin
      slots_o.mask[k] = last_byte_i;
    end
    slots_o.last = last_byte_i;
    if (st_i.byte_cnt >= cfg_i.max_in) begin
      slots_o.status = StInLong;
    end else if (nl_new >= cfg_i.max_name) begin
      slots_o.status = StNameLong;
    end else begin
      slots_o.status = StOk;
    end
  end

  always_comb begin
    if (last_byte_i) begin
      st_o = '0;
    end else begin
      st_o.bit_buf   = acc[3:0] & keep_mask;
      st_o.bit_cnt   = rem;
      st_o.label_pos = pos;
      st_o.name_len  = nl_new;
      st_o.byte_cnt  = (st_i.byte_cnt == 8'hFF) ? 8'hFF : st_i.byte_cnt + 8'd1;
    end
  end

endmodule

// File: design/b32dns_outbuf.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b32dns_outbuf import b32dns_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,
  input  slots_t     slots_i,
  output logic       free_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_char_o,
  output logic       last_char_o,
  output logic [1:0] status_o
);

  logic [NumSlots-1:0]      mask_q, mask_d;
  logic [NumSlots-1:0][7:0] chars_q;
  logic                     last_q;
  status_e                  status_q;
  logic [NumSlots-1:0]      sel;
  logic                     final_slot;
  logic                     take;

  // Lowest pending slot goes out first.
  assign sel         = mask_q & (~mask_q + NumSlots'(1));
  assign out_valid_o = |mask_q;
  assign final_slot  = $onehot(mask_q);
  assign take        = out_valid_o && out_ready_i;
  assign free_o      = !out_valid_o || (final_slot && out_ready_i);

  always_comb begin
    out_char_o = '0;
    for (int k = 0; k < NumSlots; k++) begin
      out_char_o = out_char_o | (chars_q[k] & {8{sel[k]}});
    end
  end

  assign last_char_o = last_q && sel[SlotLast];
  assign status_o    = last_char_o ? status_q : StOk;

  always_comb begin
    mask_d = mask_q;
    if (load_i) begin
      mask_d = slots_i.mask;
    end else if (take) begin
      mask_d = mask_q & ~sel;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else begin
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      chars_q  <= slots_i.chars;
      last_q   <= slots_i.last;
      status_q <= slots_i.status;
    end
  end

  `ASSERT_IMP(a_load_only_when_free, load_i, free_o)
  `ASSERT_IMP(a_last_char_is_final, out_valid_o && last_char_o, final_slot)
  `ASSERT_NXT(a_load_fills_buffer, load_i && (slots_i.mask != '0), out_valid_o)

endmodule

// File: design/base32_dns_label_encoder.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Base32 DNS name encoder: message bytes in, name characters out.
// Input channel: one message byte per word (data_byte_i, last_byte_i marks the
// final byte). Output channel: one character per word (out_char_o); the final
// character of a name has last_char_o set and carries status_o (ok, input too
// long, name too long); status_o reads ok on every other word.
// Configuration: write cfg_wdata_i to register cfg_idx_i while cfg_we_i is high;
// write it only while the block is idle.
// Path: an accepted byte waits in the input register and moves into the character
// buffer once the buffer is free; its characters are taken from there.
// Throughput: while out_ready_i is high the output runs one character per cycle.
// A byte yields one or two characters, plus a label dot now and then, and up
// to nine on the last byte (final bits, dot, the ".Gnn." suffix).
// The next byte sits in the input register and moves into the buffer in the
// cycle its predecessor's final character is taken, so no cycle is lost.
// Stall: while out_ready_i is low the current character holds; a second byte is
// still taken into the input register, then in_ready_o drops.
// Reset: clears encoder state and buffers; registers return to their defaults.

module base32_dns_label_encoder import b32dns_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [7:0]          data_byte_i,
  input  logic                last_byte_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_char_o,
  output logic                last_char_o,
  output logic [1:0]          status_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  cfg_t       cfg_q;
  enc_state_t st_q, st_d;
  slots_t     slots;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       buf_free;
  logic       load;

  // Configuration registers: plain write, no read-back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tag       <= TagReset;
      cfg_q.max_in    <= MaxInReset;
      cfg_q.max_name  <= MaxNameReset;
      cfg_q.label_len <= LabelReset;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CfgTag:     cfg_q.tag       <= cfg_wdata_i[6:0];
        CfgMaxIn:   cfg_q.max_in    <= cfg_wdata_i[7:0];
        CfgMaxName: cfg_q.max_name  <= cfg_wdata_i[8:0];
        CfgLabel:   cfg_q.label_len <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  // Input register: take a new word when none is held or the held one moves on this cycle.
  assign load       = in_valid_q && buf_free;
  assign in_ready_o = !in_valid_q || load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= data_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  // Expand the held byte into its characters and the state it leaves behind.
  b32dns_expand u_expand (
    .cfg_i       (cfg_q),
    .st_i        (st_q),
    .data_byte_i (in_byte_q),
    .last_byte_i (in_last_q),
    .slots_o     (slots),
    .st_o        (st_d)
  );

  // Encoder state advances only when a byte's characters enter the buffer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (load) begin
      st_q <= st_d;
    end
  end

  b32dns_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .slots_i     (slots),
    .free_o      (buf_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o),
    .status_o    (status_o)
  );

  `ASSERT_IMP(a_bit_cnt_range, in_valid_q || !in_valid_q, st_q.bit_cnt <= 3'd4)
  `ASSERT_NXT(a_clear_after_last, load && in_last_q, st_q == '0)
  `ASSERT_IMP(a_result_bound, load, $countones(slots.mask) <= 9)

endmodule
